// ===== sv/sliding_sma_and_rsi_indicator_top_assert.svh =====
// Assertion macros for the moving average / strength index block.
// Each macro expands to one concurrent assertion in simulation and to nothing in synthesis.
`ifndef SLIDING_SMA_AND_RSI_INDICATOR_TOP_ASSERT_SVH
`define SLIDING_SMA_AND_RSI_INDICATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define SMARSI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smarsi: same-cycle check failed");

// ante holds -> cons holds in the next cycle
`define SMARSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smarsi: next-cycle check failed");

`else

`define SMARSI_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SMARSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/smarsi_pkg.sv =====
`timescale 1ns / 1ps

package smarsi_pkg;

	// default sizing
	localparam int DEFAULT_WINDOW_DEPTH = 256;
	localparam int DEFAULT_PRICE_BITS   = 32;

	// fixed field widths
	localparam int PRICE_IN_W  = 32;
	localparam int AVG_W       = 32;
	localparam int RSI_W       = 15;
	localparam int OUT_DATA_W  = 48;
	localparam int OUT_USER_W  = 2;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 9;
	localparam int SMA_REG_W   = 9;
	localparam int RSI_REG_W   = 8;

	// register map
	localparam logic [CFG_INDEX_W-1:0] REG_SMA_WINDOW = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_RSI_WINDOW = CFG_INDEX_W'(1);

	localparam logic [SMA_REG_W-1:0] SMA_RESET = SMA_REG_W'(20);
	localparam logic [RSI_REG_W-1:0] RSI_RESET = RSI_REG_W'(14);

	// strength index scale: 100 * 256 = 25 << 10
	localparam logic [RSI_W-1:0] RSI_HALF = RSI_W'(12800);
	localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(25600);
	localparam int RSI_SCALE_SHIFT = 10;
	localparam int NORM_BITS       = 49;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_SW,
		ST_RD_PREV,
		ST_RD_OLD,
		ST_RD_NEW,
		ST_CHG_OUT,
		ST_APPLY,
		ST_SUMS,
		ST_NORM,
		ST_MUL1,
		ST_MUL2,
		ST_RSI_START,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== sv/sliding_sma_and_rsi_indicator_top.sv =====
`timescale 1ns / 1ps
`include "sliding_sma_and_rsi_indicator_top_assert.svh"

// Sliding simple moving average and simple-average strength index.
// Input stream (s_axis_*): one closing price per word, unsigned Q24.8.
// Output stream (m_axis_*): one word per input word: windowed mean price,
//   strength index in 1/256 units, and two ready flags in tuser.
// Config channel (cfg_*): index 0 = averaging window, index 1 = strength window.
//   A write to either register restarts warm-up. Write only while the block is idle.
// One word is worked on at a time. With SUM_W = PRICE_BITS + clog2(WINDOW_DEPTH),
//   the bit-serial average divider makes SUM_W quotient bits, one quotient bit per cycle.
//   The strength divider runs alongside it, 15 bits at one bit per cycle. Strength sums
//   that reach 2^49 are halved in the NORM state before that divide. m_axis_tvalid rises
//   once both dividers are done and the output register is free.
// The price ring is a single memory with one read port and one write port. The
//   four history reads per word are issued in states RD_SW, RD_PREV, RD_OLD and RD_NEW.
// Reset: both windows go to their defaults (20 and 14), and the sums and counters
//   clear. Ring contents are not cleared; the sample count guards every read.
// Back-pressure: the result sits in an output register. s_axis_tready comes back
//   once the work is done. If m_axis_tready is low the block holds the next result
//   in its DONE state until the output register frees up.
module sliding_sma_and_rsi_indicator_top #(
	parameter int WINDOW_DEPTH = smarsi_pkg::DEFAULT_WINDOW_DEPTH,
	parameter int PRICE_BITS   = smarsi_pkg::DEFAULT_PRICE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smarsi_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [smarsi_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [smarsi_pkg::PRICE_IN_W-1:0]   s_axis_tdata,   // [31:0] close_price
	// output stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [smarsi_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [31:0] average_price,
	                                                            // [46:32] strength_index, pad
	output logic [smarsi_pkg::OUT_USER_W-1:0]   m_axis_tuser    // [0] average_ready,
	                                                            // [1] strength_ready
);
	import smarsi_pkg::*;

	localparam int AW     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW     = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = PRICE_BITS + AW;
	// g * 25 needs 5 more bits; 25 << 10 scales to 15 quotient bits
	localparam int LOW_SH = RSI_W - RSI_SCALE_SHIFT;
	localparam int G25_W  = SUM_W + LOW_SH;
	localparam int ACNT_W = $clog2(SUM_W + 1);
	localparam int RCNT_W = $clog2(RSI_W + 1);
	localparam int QX_W   = (SUM_W > AVG_W) ? SUM_W : AVG_W;
	localparam int PAD_W  = OUT_DATA_W - AVG_W - RSI_W;

	// control state
	state_t                state_q, state_d;
	logic [SMA_REG_W-1:0]  sma_q;
	logic [RSI_REG_W-1:0]  rsi_q;
	logic [AW-1:0]         wp_q;
	logic [CW-1:0]         samples_q;
	logic [SUM_W-1:0]      wsum_q, gain_q, loss_q;
	logic                  avg_busy_q, rsi_busy_q, m_valid_q;
	logic [ACNT_W-1:0]     avg_cnt_q;
	logic [RCNT_W-1:0]     rcnt_q;

	// per-word payload
	logic [PRICE_BITS-1:0] price_q, rd_q, old_q, in_mag_q, out_mag_q;
	logic                  in_up_q, out_up_q;
	logic [CW-1:0]         sw_q, rw_q;
	logic                  sub_en_q, in_en_q, out_en_q, sma_ok_q, rsi_ok_q;

	// average divider
	logic [SUM_W-1:0]      avg_dq_q;
	logic [CW-1:0]         avg_rem_q;
	logic [CW:0]           avg_try;
	logic                  avg_ge;
	logic [QX_W-1:0]       avg_qx;
	logic [AVG_W-1:0]      avg_sat;

	// strength divider
	logic [SUM_W-1:0]      g_q, t_q, rem_q;
	logic                  loss_zero_q;
	logic [G25_W-1:0]      num_q;
	logic [RSI_W-1:0]      low_q, res_q;
	logic [SUM_W:0]        rsi_try;
	logic                  rsi_ge;

	// output register
	logic [AVG_W-1:0]      avg_out_q;
	logic [RSI_W-1:0]      rsi_out_q;
	logic                  avg_rdy_q, rsi_rdy_q;

	// misc
	logic [PRICE_BITS-1:0] price_c;
	logic [CW-1:0]         sw_c, rw_c, rd_k;
	logic [AW:0]           back_sum;
	logic [AW-1:0]         rd_addr;
	logic                  in_ready, ring_we, out_load, accept, cfg_restart;

	logic [PRICE_BITS-1:0] ring [WINDOW_DEPTH];

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = in_ready;
	assign accept        = in_ready && s_axis_tvalid;
	assign price_c       = PRICE_BITS'(s_axis_tdata);
	assign cfg_restart   = cfg_valid &&
		(cfg_index == REG_SMA_WINDOW || cfg_index == REG_RSI_WINDOW);

	// window clamps: zero acts as one, oversize saturates to what the ring holds
	always_comb begin
		if (sma_q == '0) begin
			sw_c = CW'(1);
		end else if (int'(sma_q) > WINDOW_DEPTH) begin
			sw_c = CW'(WINDOW_DEPTH);
		end else begin
			sw_c = CW'(sma_q);
		end
		if (rsi_q == '0) begin
			rw_c = CW'(1);
		end else if (int'(rsi_q) > WINDOW_DEPTH - 1) begin
			rw_c = CW'(WINDOW_DEPTH - 1);
		end else begin
			rw_c = CW'(rsi_q);
		end
	end

	// ring index k words back, modulo depth
	always_comb begin
		back_sum = (AW+1)'(wp_q) + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(rd_k);
		if (back_sum >= (AW+1)'(WINDOW_DEPTH)) begin
			rd_addr = AW'(back_sum - (AW+1)'(WINDOW_DEPTH));
		end else begin
			rd_addr = AW'(back_sum);
		end
	end

	// divider step logic
	assign avg_try = {avg_rem_q, avg_dq_q[SUM_W-1]};
	assign avg_ge  = avg_try >= {1'b0, sw_q};
	assign avg_qx  = QX_W'(avg_dq_q);
	assign avg_sat = (|(avg_qx >> AVG_W)) ? '1 : avg_qx[AVG_W-1:0];
	assign rsi_try = {rem_q, low_q[RSI_W-1]};
	assign rsi_ge  = rsi_try >= {1'b0, t_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (s_axis_tvalid) state_d = ST_RD_SW;
			ST_RD_SW:     state_d = ST_RD_PREV;
			ST_RD_PREV:   state_d = ST_RD_OLD;
			ST_RD_OLD:    state_d = ST_RD_NEW;
			ST_RD_NEW:    state_d = ST_CHG_OUT;
			ST_CHG_OUT:   state_d = ST_APPLY;
			ST_APPLY:     state_d = ST_SUMS;
			ST_SUMS:      state_d = ST_NORM;
			ST_NORM: begin
				if (!rsi_ok_q || t_q == '0 || loss_zero_q) begin
					state_d = ST_WAIT;
				end else if (!(|(t_q >> NORM_BITS))) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1:      state_d = ST_MUL2;
			ST_MUL2:      state_d = ST_RSI_START;
			ST_RSI_START: state_d = ST_WAIT;
			ST_WAIT:      if (!avg_busy_q && !rsi_busy_q) state_d = ST_DONE;
			ST_DONE:      if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// state outputs: read offset, ring write, handshake strobes
	always_comb begin
		in_ready = 1'b0;
		ring_we  = 1'b0;
		out_load = 1'b0;
		rd_k     = sw_q;
		case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_RD_SW:   rd_k = sw_q;
			ST_RD_PREV: rd_k = CW'(1);
			ST_RD_OLD:  rd_k = rw_q + 1'b1;
			ST_RD_NEW:  rd_k = rw_q;
			ST_CHG_OUT: ring_we = 1'b1;
			ST_DONE:    out_load = !m_valid_q || m_axis_tready;
			default:    ;
		endcase
	end

	// price ring
	always_ff @(posedge clk) begin
		rd_q <= ring[rd_addr];
		if (ring_we) begin
			ring[wp_q] <= price_q;
		end
	end

	// control and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sma_q      <= SMA_RESET;
			rsi_q      <= RSI_RESET;
			wp_q       <= '0;
			samples_q  <= '0;
			wsum_q     <= '0;
			gain_q     <= '0;
			loss_q     <= '0;
			avg_busy_q <= 1'b0;
			avg_cnt_q  <= '0;
			rsi_busy_q <= 1'b0;
			rcnt_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				wsum_q <= wsum_q + SUM_W'(price_c);
			end
			if (state_q == ST_RD_PREV && sub_en_q) begin
				wsum_q <= wsum_q - SUM_W'(rd_q);
			end
			// newest change enters the window
			if (state_q == ST_RD_NEW) begin
				if (in_up_q) begin
					gain_q <= gain_q + SUM_W'(in_mag_q);
				end else begin
					loss_q <= loss_q + SUM_W'(in_mag_q);
				end
			end
			// oldest change leaves the window
			if (state_q == ST_APPLY) begin
				if (out_up_q) begin
					gain_q <= gain_q - SUM_W'(out_mag_q);
				end else begin
					loss_q <= loss_q - SUM_W'(out_mag_q);
				end
			end
			if (ring_we) begin
				wp_q <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (samples_q != CW'(WINDOW_DEPTH)) begin
					samples_q <= samples_q + 1'b1;
				end
			end

			if (state_q == ST_RD_OLD) begin
				avg_busy_q <= 1'b1;
				avg_cnt_q  <= ACNT_W'(SUM_W);
			end else if (avg_busy_q) begin
				avg_cnt_q <= avg_cnt_q - 1'b1;
				if (avg_cnt_q == ACNT_W'(1)) avg_busy_q <= 1'b0;
			end

			if (state_q == ST_RSI_START) begin
				rsi_busy_q <= 1'b1;
				rcnt_q     <= RCNT_W'(RSI_W);
			end else if (rsi_busy_q) begin
				rcnt_q <= rcnt_q - 1'b1;
				if (rcnt_q == RCNT_W'(1)) rsi_busy_q <= 1'b0;
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					REG_SMA_WINDOW: sma_q <= cfg_data[SMA_REG_W-1:0];
					REG_RSI_WINDOW: rsi_q <= cfg_data[RSI_REG_W-1:0];
					default:        ;
				endcase
			end
			if (cfg_restart) begin
				wp_q      <= '0;
				samples_q <= '0;
				wsum_q    <= '0;
				gain_q    <= '0;
				loss_q    <= '0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			price_q  <= price_c;
			sw_q     <= sw_c;
			rw_q     <= rw_c;
			sub_en_q <= samples_q >= sw_c;
			in_en_q  <= samples_q != '0;
			out_en_q <= samples_q > rw_c;
			sma_ok_q <= ((CW+1)'(samples_q) + (CW+1)'(1)) >= (CW+1)'(sw_c);
			rsi_ok_q <= samples_q >= rw_c;
		end

		// change from previous price; equal prices add zero
		if (state_q == ST_RD_OLD) begin
			in_up_q <= in_en_q && (price_q > rd_q);
			if (!in_en_q) begin
				in_mag_q <= '0;
			end else if (price_q > rd_q) begin
				in_mag_q <= price_q - rd_q;
			end else begin
				in_mag_q <= rd_q - price_q;
			end
		end
		if (state_q == ST_RD_NEW) begin
			old_q <= rd_q;
		end
		if (state_q == ST_CHG_OUT) begin
			out_up_q <= out_en_q && (rd_q > old_q);
			if (!out_en_q) begin
				out_mag_q <= '0;
			end else if (rd_q > old_q) begin
				out_mag_q <= rd_q - old_q;
			end else begin
				out_mag_q <= old_q - rd_q;
			end
		end

		// restoring divide of the window sum, one quotient bit per cycle
		if (state_q == ST_RD_OLD) begin
			avg_dq_q  <= wsum_q;
			avg_rem_q <= '0;
		end else if (avg_busy_q) begin
			avg_dq_q  <= {avg_dq_q[SUM_W-2:0], avg_ge};
			avg_rem_q <= avg_ge ? CW'(avg_try - {1'b0, sw_q}) : avg_try[CW-1:0];
		end

		if (state_q == ST_SUMS) begin
			g_q         <= gain_q;
			t_q         <= gain_q + loss_q;
			loss_zero_q <= loss_q == '0;
		end
		if (state_q == ST_NORM) begin
			if (!rsi_ok_q || t_q == '0) begin
				res_q <= RSI_HALF;
			end else if (loss_zero_q) begin
				res_q <= RSI_FULL;
			end else if (|(t_q >> NORM_BITS)) begin
				g_q <= g_q >> 1;
				t_q <= t_q >> 1;
			end
		end
		// g * 25 = (g << 3) + g + (g << 4)
		if (state_q == ST_MUL1) begin
			num_q <= (G25_W'(g_q) << 3) + G25_W'(g_q);
		end
		if (state_q == ST_MUL2) begin
			num_q <= num_q + (G25_W'(g_q) << 4);
		end
		// dividend is g*25 << 10; top part already below t since g <= t
		if (state_q == ST_RSI_START) begin
			rem_q <= num_q[G25_W-1:LOW_SH];
			low_q <= {num_q[LOW_SH-1:0], {RSI_SCALE_SHIFT{1'b0}}};
			res_q <= '0;
		end else if (rsi_busy_q) begin
			rem_q <= rsi_ge ? SUM_W'(rsi_try - {1'b0, t_q}) : rsi_try[SUM_W-1:0];
			low_q <= {low_q[RSI_W-2:0], 1'b0};
			res_q <= {res_q[RSI_W-2:0], rsi_ge};
		end

		if (out_load) begin
			avg_out_q <= sma_ok_q ? avg_sat : '0;
			avg_rdy_q <= sma_ok_q;
			rsi_out_q <= res_q;
			rsi_rdy_q <= rsi_ok_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, rsi_out_q, avg_out_q};
	assign m_axis_tuser  = {rsi_rdy_q, avg_rdy_q};

	`SMARSI_ASSERT_NOW(a_rsi_range, clk, arst_n, m_valid_q, rsi_out_q <= RSI_FULL)
	`SMARSI_ASSERT_NOW(a_avg_rem_bound, clk, arst_n, avg_busy_q, avg_rem_q < sw_q)
	`SMARSI_ASSERT_NOW(a_rsi_rem_bound, clk, arst_n, rsi_busy_q, rem_q < t_q)
	`SMARSI_ASSERT_NEXT(a_accept_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
